[rtl/rpb_pkg.sv]
// Shared types and constants for the RGB pixel blend unit.
// Depends on nothing; every other file of the block imports it.

package rpb_pkg;

  // Blend operation codes; codes above OP_ADD carry no meaning and give black.
  typedef enum logic [2:0] {
    OP_MULTIPLY = 3'd0,
    OP_SCREEN   = 3'd1,
    OP_OVERLAY  = 3'd2,
    OP_SUBTRACT = 3'd3,
    OP_ADD      = 3'd4
  } blend_op_e;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned OffsetW = 9;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_OFFSET_RED   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET_GREEN = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET_BLUE  = 2'd2;

  typedef struct packed {
    logic [2:0]       operation;
    logic [ChanW-1:0] top_blue;
    logic [ChanW-1:0] top_green;
    logic [ChanW-1:0] top_red;
    logic [ChanW-1:0] bottom_blue;
    logic [ChanW-1:0] bottom_green;
    logic [ChanW-1:0] bottom_red;
  } pixel_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_red;
  } pixel_out_t;

endpackage

[rtl/rpb_channel.sv]
// Blend logic for one color channel: one 8x8 multiplier, a rounded divide by 255,
// and the subtract and offset-add clamps. Depends on rpb_pkg.

module rpb_channel
  import rpb_pkg::*;
(
  input  logic [2:0]         op_i,
  input  logic [ChanW-1:0]   top_i,
  input  logic [ChanW-1:0]   bottom_i,
  input  logic [OffsetW-1:0] offset_i,
  output logic [ChanW-1:0]   result_o
);

  localparam logic [ChanW-1:0] ChanMax = {ChanW{1'b1}};

  // Round-to-nearest x/255 for x up to 255*255, using the add-and-shift identity.
  function automatic logic [ChanW-1:0] div255_round(input logic [16:0] x);
    logic [17:0] t;
    logic [17:0] s;
    t = {1'b0, x} + 18'd128;
    s = t + (t >> 8);
    return s[15:8];
  endfunction

  logic              invert;
  logic              double;
  logic [ChanW-1:0]  mul_a;
  logic [ChanW-1:0]  mul_b;
  logic [15:0]       product;
  logic [16:0]       scaled;
  logic [ChanW-1:0]  quot;
  logic [ChanW-1:0]  blend;
  logic [ChanW-1:0]  diff;
  logic signed [9:0] sum;
  logic [ChanW-1:0]  add_clamped;

  // Screen and the upper half of overlay work on the complemented values.
  always_comb begin
    invert = (blend_op_e'(op_i) == OP_SCREEN) ||
             ((blend_op_e'(op_i) == OP_OVERLAY) && bottom_i[ChanW-1]);
    double = (blend_op_e'(op_i) == OP_OVERLAY);
  end

  assign mul_a   = invert ? (ChanMax - top_i) : top_i;
  assign mul_b   = invert ? (ChanMax - bottom_i) : bottom_i;
  assign product = mul_a * mul_b;
  assign scaled  = double ? {product, 1'b0} : {1'b0, product};
  assign quot    = div255_round(scaled);
  assign blend   = invert ? (ChanMax - quot) : quot;

  assign diff = (top_i > bottom_i) ? (top_i - bottom_i) : '0;

  assign sum = $signed({2'b00, top_i}) + $signed({offset_i[OffsetW-1], offset_i});

  always_comb begin
    if (sum[9]) begin
      add_clamped = '0;
    end else if (sum[8]) begin
      add_clamped = ChanMax;
    end else begin
      add_clamped = sum[7:0];
    end
  end

  always_comb begin
    unique case (blend_op_e'(op_i))
      OP_MULTIPLY, OP_SCREEN, OP_OVERLAY: result_o = blend;
      OP_SUBTRACT:                        result_o = diff;
      OP_ADD:                             result_o = add_clamped;
      default:                            result_o = '0;
    endcase
  end

endmodule

[rtl/rgb_pixel_blend_unit.sv]
// Top level of the RGB pixel blend unit: input register, three channel blenders
// and the result register. Depends on rpb_pkg and rpb_channel.
//
//   Channel | Signals                              | Beat
//   --------+--------------------------------------+------------------------------
//   input   | in_valid_i, in_stall_o, in_beat_i    | operation, top and bottom BGR
//   output  | out_valid_o, out_stall_i, out_beat_o | blended BGR
//   config  | cfg_we_i, cfg_idx_i, cfg_data_i      | 9-bit signed offset per color
//
// A beat passes through the input register and then the result register, with
// the blend arithmetic (one 8x8 multiply and a rounded divide by 255 per channel)
// between them. One beat is accepted every cycle while the input is not stalled.
// Reset clears the valid flags and sets the three offsets to zero.
// A stall at the output holds the result register; the input register still
// takes a beat while it is empty, so input stall rises only when both are full.

module rgb_pixel_blend_unit
  import rpb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pixel_in_t           in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pixel_out_t          out_beat_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [OffsetW-1:0]  cfg_data_i
);

  logic [OffsetW-1:0] offset_red_q;
  logic [OffsetW-1:0] offset_green_q;
  logic [OffsetW-1:0] offset_blue_q;

  logic       in_vld_q;
  pixel_in_t  in_q;
  logic       out_vld_q;
  pixel_out_t out_q;
  pixel_out_t out_d;

  logic out_adv;
  logic in_adv;

  // Configuration writes; an index past the last register is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_red_q   <= '0;
      offset_green_q <= '0;
      offset_blue_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_OFFSET_RED) begin
        offset_red_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_OFFSET_GREEN) begin
        offset_green_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_OFFSET_BLUE) begin
        offset_blue_q <= cfg_data_i;
      end
    end
  end

  // The result register moves when it is empty or its beat is being taken;
  // the input register moves when it is empty or its beat moves on.
  assign out_adv    = !out_vld_q || !out_stall_i;
  assign in_adv     = !in_vld_q || out_adv;
  assign in_stall_o = !in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_adv) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      in_q <= in_beat_i;
    end
  end

  rpb_channel u_blue (
    .op_i     (in_q.operation),
    .top_i    (in_q.top_blue),
    .bottom_i (in_q.bottom_blue),
    .offset_i (offset_blue_q),
    .result_o (out_d.out_blue)
  );

  rpb_channel u_green (
    .op_i     (in_q.operation),
    .top_i    (in_q.top_green),
    .bottom_i (in_q.bottom_green),
    .offset_i (offset_green_q),
    .result_o (out_d.out_green)
  );

  rpb_channel u_red (
    .op_i     (in_q.operation),
    .top_i    (in_q.top_red),
    .bottom_i (in_q.bottom_red),
    .offset_i (offset_red_q),
    .result_o (out_d.out_red)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && in_vld_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_beat_o  = out_q;

`ifndef SYNTH
  // The input side stalls only when both registers hold a beat.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_vld_q))
    else $error("input stalled with a free register");

  // A beat in the input register always reaches the result register when it moves.
  a_beat_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_adv) |=> out_vld_q)
    else $error("beat lost between input and result register");

  // A beat still held at the input while the output is stalled is not dropped.
  a_beat_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_adv) |=> (in_vld_q && $stable(in_q)))
    else $error("input register changed while blocked");

  // Operation codes without a meaning give a black pixel.
  a_unused_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_adv && (in_q.operation > OP_ADD)) |=> (out_q == '0))
    else $error("unused operation code gave a non-zero pixel");
`endif

endmodule
